@@ rtl/core/mcg_pkg.sv @@
// month calendar grid package: widths, arithmetic constants, fsm states,
// command and status structs and small calendar lookup functions
// no dependencies
package mcg_pkg;

	// grid shape
	localparam int GRID_ROWS_DEF = 6;
	localparam int COLS          = 7;

	// field widths
	localparam int YEAR_W    = 14;
	localparam int MON_W     = 4;
	localparam int DAY_W     = 5;
	localparam int OFF_W     = 12;
	localparam int COL_W     = 3;
	localparam int ROW_W     = 3;
	localparam int WD_W      = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 3;

	// internal widths: biased month total and year held as year + 400
	localparam int TOT_W = 18;
	localparam int YZ_W  = 15;
	localparam int Q_W   = 15;
	localparam int HZ_W  = 8;
	localparam int SUM_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WEEK_START     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WEEKEND_START  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WEEKEND_LENGTH = 2'd2;

	// register reset values
	localparam logic [CFG_W-1:0] WEEK_START_RST     = 3'd1;
	localparam logic [CFG_W-1:0] WEEKEND_START_RST  = 3'd6;
	localparam logic [CFG_W-1:0] WEEKEND_LENGTH_RST = 3'd2;

	// month total is biased by 256 years so that it stays positive
	localparam int TOT_BIAS = 12 * 256 - 1;
	// quotient of biased total to year + 400
	localparam int Q_TO_YZ  = 400 - 256;
	localparam int YEAR_OFS = 400;

	// reciprocal constants for division by constants
	localparam logic [16:0] RECIP3   = 17'd43691;
	localparam int          RECIP3_SH = 17;
	localparam logic [12:0] RECIP100 = 13'd5243;
	localparam int          RECIP100_SH = 19;
	localparam logic [15:0] RECIP7   = 16'd37450;
	localparam int          RECIP7_SH = 18;

	// weekday offset of day number plus four, reduced mod 7
	localparam logic [SUM_W-1:0] WD_CONST = 16'd3;

	localparam logic [WD_W-1:0]  LAST_WD  = 3'd6;
	localparam logic [MON_W-1:0] DECEMBER = 4'd12;
	localparam logic [MON_W-1:0] JANUARY  = 4'd1;
	localparam logic [MON_W-1:0] FEBRUARY = 4'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_YEAR,
		ST_CENT,
		ST_SUM,
		ST_MOD,
		ST_START,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div;
		logic year;
		logic cent;
		logic sum;
		logic wmod;
		logic init;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
	} stat_t;

	// normalised configuration
	typedef struct packed {
		logic [WD_W-1:0]  week_start;
		logic [WD_W-1:0]  weekend_start;
		logic [CFG_W-1:0] weekend_length;
	} cfg_t;

	// days in month, february only in the grid's target year
	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			FEBRUARY:                  len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// day of year of the 1st, march based, reduced mod 7
	function automatic logic [WD_W-1:0] doy_mod7(input logic [MON_W-1:0] m);
		logic [WD_W-1:0] r;
		unique case (m)
			4'd1:    r = 3'd5;
			4'd2:    r = 3'd1;
			4'd3:    r = 3'd0;
			4'd4:    r = 3'd3;
			4'd5:    r = 3'd5;
			4'd6:    r = 3'd1;
			4'd7:    r = 3'd3;
			4'd8:    r = 3'd6;
			4'd9:    r = 3'd2;
			4'd10:   r = 3'd4;
			4'd11:   r = 3'd0;
			default: r = 3'd2;
		endcase
		return r;
	endfunction

	// (a - b) mod 7 for weekdays 0..6
	function automatic logic [WD_W-1:0] wd_sub(input logic [WD_W-1:0] a,
			input logic [WD_W-1:0] b);
		logic [WD_W:0] d;
		if (a >= b) begin
			d = {1'b0, a} - {1'b0, b};
		end else begin
			d = {1'b0, a} + 4'd7 - {1'b0, b};
		end
		return d[WD_W-1:0];
	endfunction

	// weekday seven is taken as sunday
	function automatic logic [WD_W-1:0] wd_norm(input logic [WD_W-1:0] a);
		return (a == 3'd7) ? 3'd0 : a;
	endfunction

endpackage

@@ rtl/core/mcg_ctrl.sv @@
// month calendar grid controller: sequences the date arithmetic steps
// and the cell emission; depends on mcg_pkg
module mcg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mcg_pkg::stat_t stat,
	output mcg_pkg::cmd_t cmd,
	output logic          busy,
	output logic          cell_strobe
);
	import mcg_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_YEAR;
			end
			ST_YEAR: begin
				cmd.year = 1'b1;
				state_d  = ST_CENT;
			end
			ST_CENT: begin
				cmd.cent = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_MOD;
			end
			ST_MOD: begin
				cmd.wmod = 1'b1;
				state_d  = ST_START;
			end
			ST_START: begin
				cmd.init = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign cell_strobe = (state_q == ST_EMIT);

endmodule

@@ rtl/core/mcg_datapath.sv @@
// month calendar grid datapath: target month, weekday of the 1st by
// reciprocal multiplies, and the running cell date; depends on mcg_pkg
module mcg_datapath #(
	parameter int GRID_ROWS = mcg_pkg::GRID_ROWS_DEF
) (
	input  logic                          clk,
	input  mcg_pkg::cmd_t                 cmd,
	input  mcg_pkg::cfg_t                 cfg,
	input  logic [mcg_pkg::YEAR_W-1:0]    today_year,
	input  logic [mcg_pkg::MON_W-1:0]     today_month,
	input  logic [mcg_pkg::DAY_W-1:0]     today_day,
	input  logic signed [mcg_pkg::OFF_W-1:0] month_offset,
	output mcg_pkg::stat_t                stat,
	output logic [mcg_pkg::DAY_W-1:0]     day_of_month,
	output logic [mcg_pkg::COL_W-1:0]     column,
	output logic [mcg_pkg::ROW_W-1:0]     row,
	output logic                          in_month,
	output logic                          is_today,
	output logic                          is_weekend,
	output logic                          last_cell
);
	import mcg_pkg::*;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);

	// request registers
	logic [YZ_W-1:0]  tz_q;
	logic [MON_W-1:0] tm_q;
	logic [DAY_W-1:0] td_q;
	logic [TOT_W-1:0] t_q;

	// arithmetic step registers
	logic [Q_W-1:0]   q_q;
	logic [MON_W-1:0] gm_q;
	logic [YZ_W-1:0]  gz_q;
	logic             lt_q;
	logic [HZ_W-1:0]  hz_q;
	logic             rz0_q;
	logic             leap_q;
	logic [SUM_W-1:0] s_q;
	logic [WD_W-1:0]  wd1_q;

	// cell registers
	logic [DAY_W-1:0] cd_q;
	logic [MON_W-1:0] cm_q;
	logic [YZ_W-1:0]  cy_q;
	logic [WD_W-1:0]  wd_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// biased month total
	logic [TOT_W:0] ty_ext, tot;
	assign ty_ext = {{(TOT_W + 1 - YEAR_W){1'b0}}, today_year};
	assign tot    = (ty_ext << 3) + (ty_ext << 2)
		+ {{(TOT_W + 1 - MON_W){1'b0}}, today_month}
		+ {{(TOT_W + 1 - OFF_W){month_offset[OFF_W-1]}}, month_offset}
		+ (TOT_W + 1)'(TOT_BIAS);

	// total / 12 as (total / 4) / 3
	logic [32:0] p3;
	assign p3 = {17'd0, t_q[TOT_W-1:2]} * {16'd0, RECIP3};

	// remainder gives the target month
	logic [TOT_W-1:0] rem;
	assign rem = t_q - ({q_q, 3'b000} + {1'b0, q_q, 2'b00});

	// century of year + 400
	logic [27:0]     p100;
	logic [HZ_W-1:0] hz;
	logic [YZ_W-1:0] rz;
	assign p100 = {13'd0, gz_q} * {15'd0, RECIP100};
	assign hz   = p100[RECIP100_SH + HZ_W - 1:RECIP100_SH];
	assign rz   = gz_q - (({7'd0, hz} << 6) + ({7'd0, hz} << 5) + ({7'd0, hz} << 2));

	// weekday sum for the 1st, year shifted back for january and february
	logic [YZ_W-1:0]  y;
	logic [HZ_W-1:0]  hy;
	logic [SUM_W-1:0] s;
	assign y  = gz_q - {{(YZ_W - 1){1'b0}}, lt_q};
	assign hy = hz_q - {{(HZ_W - 1){1'b0}}, lt_q & rz0_q};
	assign s  = {1'b0, y} + {3'b000, y[YZ_W-1:2]} - {8'd0, hy}
		+ {10'd0, hy[HZ_W-1:2]} + {13'd0, doy_mod7(gm_q)} + WD_CONST;

	// sum mod 7
	logic [31:0]      p7;
	logic [13:0]      qs;
	logic [SUM_W:0]   q7;
	logic [SUM_W-1:0] r7;
	assign p7 = {16'd0, s_q} * {16'd0, RECIP7};
	assign qs = p7[RECIP7_SH + 13:RECIP7_SH];
	assign q7 = {qs, 3'b000} - {3'b000, qs};
	assign r7 = s_q - q7[SUM_W-1:0];

	// grid start: back up into the previous month
	logic [WD_W-1:0]  back;
	logic [MON_W-1:0] pm;
	logic [YZ_W-1:0]  py;
	assign back = wd_sub(wd1_q, cfg.week_start);
	assign pm   = (gm_q == JANUARY) ? DECEMBER : gm_q - 4'd1;
	assign py   = (gm_q == JANUARY) ? gz_q - 15'd1 : gz_q;

	logic last;
	assign last = (row_q == LAST_ROW) && (col_q == LAST_COL);

	// request and step registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tz_q <= {1'b0, today_year} + YZ_W'(YEAR_OFS);
			tm_q <= today_month;
			td_q <= today_day;
			t_q  <= tot[TOT_W-1:0];
		end
		if (cmd.div) begin
			q_q <= p3[RECIP3_SH + Q_W - 1:RECIP3_SH];
		end
		if (cmd.year) begin
			gm_q <= rem[MON_W-1:0] + 4'd1;
			gz_q <= q_q + Q_W'(Q_TO_YZ);
			lt_q <= (rem[MON_W-1:0] < 4'd2);
		end
		if (cmd.cent) begin
			hz_q   <= hz;
			rz0_q  <= (rz == '0);
			leap_q <= (gz_q[1:0] == 2'b00) && ((rz != '0) || (hz[1:0] == 2'b00));
		end
		if (cmd.sum) begin
			s_q <= s;
		end
		if (cmd.wmod) begin
			wd1_q <= r7[WD_W-1:0];
		end
	end

	// cell date and position
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			wd_q  <= cfg.week_start;
			col_q <= '0;
			row_q <= '0;
			if (back == '0) begin
				cd_q <= 5'd1;
				cm_q <= gm_q;
				cy_q <= gz_q;
			end else begin
				cd_q <= month_len(pm, leap_q) - {2'b00, back} + 5'd1;
				cm_q <= pm;
				cy_q <= py;
			end
		end else if (cmd.emit) begin
			wd_q <= (wd_q == LAST_WD) ? '0 : wd_q + 3'd1;
			if (col_q == LAST_COL) begin
				col_q <= '0;
				row_q <= row_q + 3'd1;
			end else begin
				col_q <= col_q + 3'd1;
			end
			if (cd_q == month_len(cm_q, leap_q)) begin
				cd_q <= 5'd1;
				if (cm_q == DECEMBER) begin
					cm_q <= JANUARY;
					cy_q <= cy_q + 15'd1;
				end else begin
					cm_q <= cm_q + 4'd1;
				end
			end else begin
				cd_q <= cd_q + 5'd1;
			end
		end
	end

	// cell outputs
	logic [WD_W-1:0] wk_ofs;
	assign wk_ofs = wd_sub(wd_q, cfg.weekend_start);

	assign day_of_month = cd_q;
	assign column       = col_q;
	assign row          = row_q;
	assign in_month     = (cy_q == gz_q) && (cm_q == gm_q);
	assign is_today     = (cy_q == tz_q) && (cm_q == tm_q) && (cd_q == td_q);
	assign is_weekend   = (wk_ofs < cfg.weekend_length);
	assign last_cell    = last;
	assign stat.last    = last;

endmodule

@@ rtl/core/month_calendar_grid.sv @@
// month calendar grid top level: configuration registers, controller and
// datapath; depends on mcg_pkg, mcg_ctrl and mcg_datapath
//
// a request (today's date and a signed month offset) is taken at a rising
// edge with start high and busy low. busy rises at once and stays high
// until the last cell of the grid has gone out.
// the block then works out the target month, the weekday of its 1st and
// the grid start in states ST_DIV, ST_YEAR, ST_CENT, ST_SUM, ST_MOD and
// ST_START, at most one reciprocal multiply in any cycle, and then emits
// GRID_ROWS*7 cells, one a cycle, in row-major order. each cell is on the
// output ports for one cycle with cell_strobe high; last_cell marks the
// final one. with start held high the next request is taken in the cycle
// after the last cell. the receiver cannot stall: each cell beat is taken
// as it is shown. register writes (cfg_we, cfg_index, cfg_data) land at
// once and are to be made by the user while busy is low; the block itself
// does not enforce this. reset returns the controller to idle and loads
// the register reset values: week starts monday, weekend saturday and
// sunday.
module month_calendar_grid #(
	parameter int GRID_ROWS = mcg_pkg::GRID_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [mcg_pkg::YEAR_W-1:0]       today_year,
	input  logic [mcg_pkg::MON_W-1:0]        today_month,
	input  logic [mcg_pkg::DAY_W-1:0]        today_day,
	input  logic signed [mcg_pkg::OFF_W-1:0] month_offset,
	input  logic                             cfg_we,
	input  logic [mcg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mcg_pkg::CFG_W-1:0]        cfg_data,
	output logic                             cell_strobe,
	output logic [mcg_pkg::DAY_W-1:0]        day_of_month,
	output logic [mcg_pkg::COL_W-1:0]        column,
	output logic [mcg_pkg::ROW_W-1:0]        row,
	output logic                             in_month,
	output logic                             is_today,
	output logic                             is_weekend,
	output logic                             last_cell
);
	import mcg_pkg::*;

	logic [CFG_W-1:0] week_start_q, weekend_start_q, weekend_length_q;
	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			week_start_q     <= WEEK_START_RST;
			weekend_start_q  <= WEEKEND_START_RST;
			weekend_length_q <= WEEKEND_LENGTH_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_WEEK_START) begin
				week_start_q <= cfg_data;
			end
			if (cfg_index == CFG_WEEKEND_START) begin
				weekend_start_q <= cfg_data;
			end
			if (cfg_index == CFG_WEEKEND_LENGTH) begin
				weekend_length_q <= cfg_data;
			end
		end
	end

	// weekday seven reads as sunday
	assign cfg.week_start     = wd_norm(week_start_q);
	assign cfg.weekend_start  = wd_norm(weekend_start_q);
	assign cfg.weekend_length = weekend_length_q;

	mcg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.stat        (stat),
		.cmd         (cmd),
		.busy        (busy),
		.cell_strobe (cell_strobe)
	);

	mcg_datapath #(
		.GRID_ROWS (GRID_ROWS)
	) u_datapath (
		.clk          (clk),
		.cmd          (cmd),
		.cfg          (cfg),
		.today_year   (today_year),
		.today_month  (today_month),
		.today_day    (today_day),
		.month_offset (month_offset),
		.stat         (stat),
		.day_of_month (day_of_month),
		.column       (column),
		.row          (row),
		.in_month     (in_month),
		.is_today     (is_today),
		.is_weekend   (is_weekend),
		.last_cell    (last_cell)
	);

	// a taken request runs its setup steps before any cell beat
	a_setup_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !cell_strobe) ##1 !cell_strobe)
		else $error("cell beat during setup");

	// the final cell ends the request
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_strobe && last_cell) |=> !busy)
		else $error("busy after last cell");

	// cell beats run back to back until the last one
	a_beats_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_strobe && !last_cell) |=> cell_strobe)
		else $error("gap in cell beats");

	// the final cell sits at the bottom right of the grid
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_strobe && last_cell) |->
		(column == 3'(COLS - 1) && row == 3'(GRID_ROWS - 1)))
		else $error("last cell out of place");

	// cell day numbers are never zero
	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		cell_strobe |-> (day_of_month != 5'd0))
		else $error("cell day zero");

endmodule
